// File: hdl/tvt_pkg.sv
// ---------------------------------------------------------------------------
// tvt_pkg
// shared types, constants and helpers of the two-view triangulation pipeline
// ---------------------------------------------------------------------------
`default_nettype none

package tvt_pkg;

    localparam int unsigned DivSteps = 33;

    localparam logic [53:0] RstInv0   = 54'd65536;
    localparam logic [53:0] RstInv1   = 54'd17179869184;
    localparam logic [53:0] RstInv2   = 54'd4503599627370496;
    localparam logic [53:0] RstTrans  = 54'd0;
    localparam logic [11:0] RstHeight = 12'd480;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_INV0, REG_INV1, REG_INV2, REG_ROT0, REG_ROT1, REG_ROT2, REG_TRANS, REG_HEIGHT
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][53:0] inv;
        logic [2:0][53:0] rot;
        logic [53:0]      trans;
        logic [11:0]      height;
    } t_cfg;

    // data that rides along the whole pipe
    typedef struct packed {
        logic [15:0]        index;
        logic signed [31:0] x1_0;
        logic signed [31:0] x1_1;
    } t_side;

    typedef struct packed {
        t_side                   side;
        logic [2:0][31:0]        a;
        logic [2:0][31:0]        b;
    } t_ab;

    typedef struct packed {
        t_side       side;
        logic        negd;
        logic        degen;
        logic        sat;
        logic [63:0] aa;
        logic [63:0] rem;
        logic [15:0] low;
        logic [32:0] quo;
    } t_div;

    // signed Q2.16 coefficient k of a packed row
    function automatic logic signed [17:0] entry18(input logic [53:0] w, input logic [1:0] k);
        logic signed [17:0] e;
        e = $signed(w[18*k +: 18]);
        return e;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -65'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/tvt_cfg.sv
// ---------------------------------------------------------------------------
// tvt_cfg
// register bank behind the apb-style port
// ---------------------------------------------------------------------------
`default_nettype none

module tvt_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    output tvt_pkg::t_cfg    o_cfg
);

    tvt_pkg::t_cfg    r_cfg;
    tvt_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = tvt_pkg::t_reg_idx'(paddr[5:3]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv    <= {tvt_pkg::RstInv2, tvt_pkg::RstInv1, tvt_pkg::RstInv0};
            r_cfg.rot    <= {tvt_pkg::RstInv2, tvt_pkg::RstInv1, tvt_pkg::RstInv0};
            r_cfg.trans  <= tvt_pkg::RstTrans;
            r_cfg.height <= tvt_pkg::RstHeight;
        end else if (w_wr) begin
            case (w_idx)
                tvt_pkg::REG_INV0:   r_cfg.inv[0] <= pwdata[53:0];
                tvt_pkg::REG_INV1:   r_cfg.inv[1] <= pwdata[53:0];
                tvt_pkg::REG_INV2:   r_cfg.inv[2] <= pwdata[53:0];
                tvt_pkg::REG_ROT0:   r_cfg.rot[0] <= pwdata[53:0];
                tvt_pkg::REG_ROT1:   r_cfg.rot[1] <= pwdata[53:0];
                tvt_pkg::REG_ROT2:   r_cfg.rot[2] <= pwdata[53:0];
                tvt_pkg::REG_TRANS:  r_cfg.trans  <= pwdata[53:0];
                tvt_pkg::REG_HEIGHT: r_cfg.height <= pwdata[11:0];
                default:             r_cfg.height <= r_cfg.height;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            tvt_pkg::REG_INV0:   prdata = {10'd0, r_cfg.inv[0]};
            tvt_pkg::REG_INV1:   prdata = {10'd0, r_cfg.inv[1]};
            tvt_pkg::REG_INV2:   prdata = {10'd0, r_cfg.inv[2]};
            tvt_pkg::REG_ROT0:   prdata = {10'd0, r_cfg.rot[0]};
            tvt_pkg::REG_ROT1:   prdata = {10'd0, r_cfg.rot[1]};
            tvt_pkg::REG_ROT2:   prdata = {10'd0, r_cfg.rot[2]};
            tvt_pkg::REG_TRANS:  prdata = {10'd0, r_cfg.trans};
            tvt_pkg::REG_HEIGHT: prdata = {52'd0, r_cfg.height};
            default:             prdata = 64'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/tvt_front.sv
// ---------------------------------------------------------------------------
// tvt_front
// normalization, rotation and cross products, six stages, gives a and b
// ---------------------------------------------------------------------------
`default_nettype none

module tvt_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  tvt_pkg::t_cfg      i_cfg,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [15:0]   i_view1_x,
    input  wire logic [15:0]   i_view1_y,
    input  wire logic [15:0]   i_view2_x,
    input  wire logic [15:0]   i_view2_y,
    input  wire logic [15:0]   i_point_index,
    output logic               o_valid,
    input  wire logic          i_ready,
    output tvt_pkg::t_ab       o_ab
);

    logic w_en1, w_en2, w_en3, w_en4, w_en5, w_en6;
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;

    // stage 1: pixel products
    logic [15:0]        w_px [2];
    logic signed [17:0] w_ys [2];
    logic signed [34:0] n1_px [2][3];
    logic signed [35:0] n1_py [2][3];
    logic signed [34:0] r1_px [2][3];
    logic signed [35:0] r1_py [2][3];
    logic [15:0]        r1_idx;

    // stage 2: normalized points
    logic signed [31:0] n2_x [2][3];
    logic signed [31:0] r2_x [2][3];
    logic [15:0]        r2_idx;

    // stage 3: rotation products
    logic signed [49:0] n3_p [3][3];
    logic signed [49:0] r3_p [3][3];
    logic signed [31:0] r3_x1 [2];
    logic signed [31:0] r3_x2 [3];
    logic [15:0]        r3_idx;

    // stage 4: c = R x1
    logic signed [31:0] n4_c [3];
    logic signed [31:0] r4_c [3];
    logic signed [31:0] r4_x1 [2];
    logic signed [31:0] r4_x2 [3];
    logic [15:0]        r4_idx;

    // stage 5: cross products
    logic signed [31:0] w_t [3];
    logic signed [63:0] n5_pa [3][2];
    logic signed [49:0] n5_pb [3][2];
    logic signed [63:0] r5_pa [3][2];
    logic signed [49:0] r5_pb [3][2];
    logic signed [31:0] r5_x1 [2];
    logic [15:0]        r5_idx;

    // stage 6
    tvt_pkg::t_ab n6_ab;
    tvt_pkg::t_ab r6_ab;

    assign w_en6   = ~r6_v | i_ready;
    assign w_en5   = ~r5_v | w_en6;
    assign w_en4   = ~r4_v | w_en5;
    assign w_en3   = ~r3_v | w_en4;
    assign w_en2   = ~r2_v | w_en3;
    assign w_en1   = ~r1_v | w_en2;
    assign o_ready = w_en1;
    assign o_valid = r6_v;
    assign o_ab    = r6_ab;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            if (w_en1) r1_v <= i_valid;
            if (w_en2) r2_v <= r1_v;
            if (w_en3) r3_v <= r2_v;
            if (w_en4) r4_v <= r3_v;
            if (w_en5) r5_v <= r4_v;
            if (w_en6) r6_v <= r5_v;
        end
    end

    // flip: y' = height*16 - y in Q.4
    always_comb begin
        w_px[0] = i_view1_x;
        w_px[1] = i_view2_x;
        w_ys[0] = $signed({2'b00, i_cfg.height, 4'b0000}) - $signed({2'b00, i_view1_y});
        w_ys[1] = $signed({2'b00, i_cfg.height, 4'b0000}) - $signed({2'b00, i_view2_y});
        for (int p = 0; p < 2; p++) begin
            for (int r = 0; r < 3; r++) begin
                n1_px[p][r] = 35'(tvt_pkg::entry18(i_cfg.inv[r], 2'd0))
                            * 35'($signed({1'b0, w_px[p]}));
                n1_py[p][r] = 36'(tvt_pkg::entry18(i_cfg.inv[r], 2'd1)) * 36'(w_ys[p]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_px  <= n1_px;
            r1_py  <= n1_py;
            r1_idx <= i_point_index;
        end
    end

    always_comb begin
        logic signed [36:0] s;
        for (int p = 0; p < 2; p++) begin
            for (int r = 0; r < 3; r++) begin
                s = 37'(r1_px[p][r]) + 37'(r1_py[p][r])
                  + (37'(tvt_pkg::entry18(i_cfg.inv[r], 2'd2)) <<< 4) + 37'sd8;
                n2_x[p][r] = 32'(s >>> 4);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_x   <= n2_x;
            r2_idx <= r1_idx;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n3_p[i][k] = 50'(tvt_pkg::entry18(i_cfg.rot[i], 2'(k))) * 50'(r2_x[0][k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_p   <= n3_p;
            r3_x1  <= '{r2_x[0][0], r2_x[0][1]};
            r3_x2  <= r2_x[1];
            r3_idx <= r2_idx;
        end
    end

    always_comb begin
        logic signed [51:0] s;
        for (int i = 0; i < 3; i++) begin
            s = 52'(r3_p[i][0]) + 52'(r3_p[i][1]) + 52'(r3_p[i][2]) + 52'sd32768;
            n4_c[i] = tvt_pkg::sat32(65'(s >>> 16));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_c   <= n4_c;
            r4_x1  <= r3_x1;
            r4_x2  <= r3_x2;
            r4_idx <= r3_idx;
        end
    end

    // v = [w]x u, w = x2
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_t[k] = 32'(tvt_pkg::entry18(i_cfg.trans, 2'(k)));
        end
        n5_pa[0][0] = 64'(r4_x2[1]) * 64'(r4_c[2]);
        n5_pa[0][1] = 64'(r4_x2[2]) * 64'(r4_c[1]);
        n5_pa[1][0] = 64'(r4_x2[2]) * 64'(r4_c[0]);
        n5_pa[1][1] = 64'(r4_x2[0]) * 64'(r4_c[2]);
        n5_pa[2][0] = 64'(r4_x2[0]) * 64'(r4_c[1]);
        n5_pa[2][1] = 64'(r4_x2[1]) * 64'(r4_c[0]);
        n5_pb[0][0] = 50'(r4_x2[1]) * 50'(w_t[2]);
        n5_pb[0][1] = 50'(r4_x2[2]) * 50'(w_t[1]);
        n5_pb[1][0] = 50'(r4_x2[2]) * 50'(w_t[0]);
        n5_pb[1][1] = 50'(r4_x2[0]) * 50'(w_t[2]);
        n5_pb[2][0] = 50'(r4_x2[0]) * 50'(w_t[1]);
        n5_pb[2][1] = 50'(r4_x2[1]) * 50'(w_t[0]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r5_pa  <= n5_pa;
            r5_pb  <= n5_pb;
            r5_x1  <= r4_x1;
            r5_idx <= r4_idx;
        end
    end

    always_comb begin
        logic signed [64:0] da;
        logic signed [50:0] db;
        n6_ab.side.index = r5_idx;
        n6_ab.side.x1_0  = r5_x1[0];
        n6_ab.side.x1_1  = r5_x1[1];
        for (int i = 0; i < 3; i++) begin
            da = 65'(r5_pa[i][0]) - 65'(r5_pa[i][1]) + 65'sd32768;
            db = 51'(r5_pb[i][0]) - 51'(r5_pb[i][1]) + 51'sd32768;
            n6_ab.a[i] = tvt_pkg::sat32(da >>> 16);
            n6_ab.b[i] = tvt_pkg::sat32(65'(db >>> 16));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en6) begin
            r6_ab <= n6_ab;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tvt_dots.sv
// ---------------------------------------------------------------------------
// tvt_dots
// a.b and a.a, sign and magnitude of the numerator, divider setup
// ---------------------------------------------------------------------------
`default_nettype none

module tvt_dots (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  tvt_pkg::t_ab    i_ab,
    output logic            o_valid,
    input  wire logic       i_ready,
    output tvt_pkg::t_div   o_div
);

    logic w_en1, w_en2, w_en3;
    logic r1_v, r2_v, r3_v;

    logic signed [63:0] n1_pab [3];
    logic signed [63:0] n1_paa [3];
    logic signed [63:0] r1_pab [3];
    logic signed [63:0] r1_paa [3];
    tvt_pkg::t_side     r1_side;

    logic signed [65:0] n2_dot;
    logic [63:0]        n2_aa;
    logic signed [65:0] r2_dot;
    logic [63:0]        r2_aa;
    tvt_pkg::t_side     r2_side;

    logic [63:0]        w_num;
    tvt_pkg::t_div      n3_div;
    tvt_pkg::t_div      r3_div;

    assign w_en3   = ~r3_v | i_ready;
    assign w_en2   = ~r2_v | w_en3;
    assign w_en1   = ~r1_v | w_en2;
    assign o_ready = w_en1;
    assign o_valid = r3_v;
    assign o_div   = r3_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (w_en1) r1_v <= i_valid;
            if (w_en2) r2_v <= r1_v;
            if (w_en3) r3_v <= r2_v;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_pab[i] = 64'($signed(i_ab.a[i])) * 64'($signed(i_ab.b[i]));
            n1_paa[i] = 64'($signed(i_ab.a[i])) * 64'($signed(i_ab.a[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_pab  <= n1_pab;
            r1_paa  <= n1_paa;
            r1_side <= i_ab.side;
        end
    end

    // squares are never negative, so their sum is taken unsigned
    assign n2_dot = 66'(r1_pab[0]) + 66'(r1_pab[1]) + 66'(r1_pab[2]);
    assign n2_aa  = 64'(unsigned'(r1_paa[0])) + 64'(unsigned'(r1_paa[1]))
                  + 64'(unsigned'(r1_paa[2]));

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_dot  <= n2_dot;
            r2_aa   <= n2_aa;
            r2_side <= r1_side;
        end
    end

    // d = -(a.b)/(a.a): d negative when a.b positive
    always_comb begin
        w_num        = (r2_dot < 66'sd0) ? 64'(-r2_dot) : 64'(r2_dot);
        n3_div.side  = r2_side;
        n3_div.negd  = (r2_dot > 66'sd0);
        n3_div.degen = (r2_aa == 64'd0);
        n3_div.sat   = ({16'd0, w_num[63:16]} >= r2_aa);
        n3_div.aa    = r2_aa;
        n3_div.rem   = {16'd0, w_num[63:16]};
        n3_div.low   = w_num[15:0];
        n3_div.quo   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_div <= n3_div;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tvt_div.sv
// ---------------------------------------------------------------------------
// tvt_div
// restoring divider, one quotient bit per stage
// ---------------------------------------------------------------------------
`default_nettype none

module tvt_div (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  tvt_pkg::t_div   i_div,
    output logic            o_valid,
    input  wire logic       i_ready,
    output tvt_pkg::t_div   o_div
);

    localparam int unsigned N = tvt_pkg::DivSteps;

    logic          r_v   [N];
    tvt_pkg::t_div r_d   [N];
    logic [N:0]    w_rdy;

    function automatic tvt_pkg::t_div div_step(input tvt_pkg::t_div d);
        tvt_pkg::t_div o;
        logic [64:0]   rem2;
        logic          ge;
        o    = d;
        rem2 = {d.rem, d.low[15]};
        ge   = (rem2 >= {1'b0, d.aa});
        o.rem = ge ? 64'(rem2 - {1'b0, d.aa}) : rem2[63:0];
        o.low = {d.low[14:0], 1'b0};
        o.quo = {d.quo[31:0], ge};
        return o;
    endfunction

    assign w_rdy[N] = i_ready;
    assign o_ready  = w_rdy[0];
    assign o_valid  = r_v[N-1];
    assign o_div    = r_d[N-1];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic          w_vin;
        tvt_pkg::t_div w_din;

        if (k == 0) begin : g_first
            assign w_vin = i_valid;
            assign w_din = i_div;
        end else begin : g_next
            assign w_vin = r_v[k-1];
            assign w_din = r_d[k-1];
        end

        assign w_rdy[k] = ~r_v[k] | w_rdy[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_d[k] <= div_step(w_din);
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/tvt_back.sv
// ---------------------------------------------------------------------------
// tvt_back
// depth rounding and clamp, scaling of x1, output register
// ---------------------------------------------------------------------------
`default_nettype none

module tvt_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  tvt_pkg::t_div      i_div,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z,
    output logic [15:0]        o_out_index,
    output logic               o_degenerate
);

    logic w_en1, w_en2, w_en3;
    logic r1_v, r2_v, r3_v;

    logic [33:0]        w_q1;
    logic [32:0]        w_mag;
    logic signed [31:0] n1_d;
    logic signed [31:0] r1_d;
    tvt_pkg::t_side     r1_side;
    logic               r1_degen;

    logic signed [63:0] r2_px;
    logic signed [63:0] r2_py;
    logic signed [31:0] r2_d;
    logic [15:0]        r2_idx;
    logic               r2_degen;

    logic signed [64:0] w_rx;
    logic signed [64:0] w_ry;

    logic signed [31:0] r3_x;
    logic signed [31:0] r3_y;
    logic signed [31:0] r3_z;
    logic [15:0]        r3_idx;
    logic               r3_degen;

    assign w_en3   = ~r3_v | ~i_stall;
    assign w_en2   = ~r2_v | w_en3;
    assign w_en1   = ~r1_v | w_en2;
    assign o_ready = w_en1;
    assign o_valid = r3_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (w_en1) r1_v <= i_valid;
            if (w_en2) r2_v <= r1_v;
            if (w_en3) r3_v <= r2_v;
        end
    end

    // 17 fraction bits, round half up into Q.16
    always_comb begin
        w_q1  = 34'(i_div.quo) + 34'd1;
        w_mag = w_q1[33:1];
        if (i_div.sat) begin
            w_mag = 33'h0FFFFFFFF;
        end
        if (i_div.degen) begin
            n1_d = 32'sd0;
        end else if (i_div.negd) begin
            if (w_mag > 33'h080000000) begin
                w_mag = 33'h080000000;
            end
            n1_d = 32'(-$signed({1'b0, w_mag}));
        end else begin
            if (w_mag > 33'h07FFFFFFF) begin
                w_mag = 33'h07FFFFFFF;
            end
            n1_d = 32'(w_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_d     <= n1_d;
            r1_side  <= i_div.side;
            r1_degen <= i_div.degen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_px    <= 64'(r1_d) * 64'(r1_side.x1_0);
            r2_py    <= 64'(r1_d) * 64'(r1_side.x1_1);
            r2_d     <= r1_d;
            r2_idx   <= r1_side.index;
            r2_degen <= r1_degen;
        end
    end

    assign w_rx = (65'(r2_px) + 65'sd32768) >>> 16;
    assign w_ry = (65'(r2_py) + 65'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_x     <= r2_degen ? 32'sd0 : tvt_pkg::sat32(w_rx);
            r3_y     <= r2_degen ? 32'sd0 : tvt_pkg::sat32(w_ry);
            r3_z     <= r2_d;
            r3_idx   <= r2_idx;
            r3_degen <= r2_degen;
        end
    end

    assign o_point_x    = r3_x;
    assign o_point_y    = r3_y;
    assign o_point_z    = r3_z;
    assign o_out_index  = r3_idx;
    assign o_degenerate = r3_degen;

endmodule

`default_nettype wire

// File: hdl/two_view_point_triangulation.sv
// throughput: one word per cycle while no stall holds the pipe; the 33-stage divider sets the depth
// a stall holds only stages that are full, bubbles close up behind it
// reset: synchronous active-low, clears all valid bits and loads register defaults
// ---------------------------------------------------------------------------
// two_view_point_triangulation
// depth of a matched point from two views, result in signed Q16.16
// ---------------------------------------------------------------------------
`default_nettype none

module two_view_point_triangulation (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // configuration port
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [5:0]    paddr,
    input  wire logic [63:0]   pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    // match words in
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [15:0]   i_view1_x,
    input  wire logic [15:0]   i_view1_y,
    input  wire logic [15:0]   i_view2_x,
    input  wire logic [15:0]   i_view2_y,
    input  wire logic [15:0]   i_point_index,
    // point words out
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z,
    output logic [15:0]        o_out_index,
    output logic               o_degenerate
);

    tvt_pkg::t_cfg w_cfg;
    tvt_pkg::t_ab  w_ab;
    tvt_pkg::t_div w_dv0;
    tvt_pkg::t_div w_dv1;

    logic w_front_rdy, w_front_v;
    logic w_dots_rdy, w_dots_v;
    logic w_div_rdy, w_div_v;
    logic w_back_rdy;

    // the user must rewrite registers only while the pipe is empty; the block does not enforce it
    tvt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // stages 1-6: flip, inverse camera, R x1, cross products
    tvt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_valid       (i_valid),
        .o_ready       (w_front_rdy),
        .i_view1_x     (i_view1_x),
        .i_view1_y     (i_view1_y),
        .i_view2_x     (i_view2_x),
        .i_view2_y     (i_view2_y),
        .i_point_index (i_point_index),
        .o_valid       (w_front_v),
        .i_ready       (w_dots_rdy),
        .o_ab          (w_ab)
    );

    // stages 7-9: dot products and divider setup
    tvt_dots u_dots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_v),
        .o_ready (w_dots_rdy),
        .i_ab    (w_ab),
        .o_valid (w_dots_v),
        .i_ready (w_div_rdy),
        .o_div   (w_dv0)
    );

    // stages 10-42: |a.b| * 2^17 / a.a
    tvt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dots_v),
        .o_ready (w_div_rdy),
        .i_div   (w_dv0),
        .o_valid (w_div_v),
        .i_ready (w_back_rdy),
        .o_div   (w_dv1)
    );

    // stages 43-45: depth, scaling, output register
    tvt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_div_v),
        .o_ready      (w_back_rdy),
        .i_div        (w_dv1),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_point_x    (o_point_x),
        .o_point_y    (o_point_y),
        .o_point_z    (o_point_z),
        .o_out_index  (o_out_index),
        .o_degenerate (o_degenerate)
    );

    assign o_stall = ~w_front_rdy;

endmodule

`default_nettype wire

// File: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// drives feature-match words into the triangulation pipe, predicts every
// point word in a local fixed-point model and compares each field on output
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int LatencyCycles = 45;
    localparam int CycleLimit    = 400000;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [15:0] idx;
        logic        degen;
    } t_point;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] v1x = '0, v1y = '0, v2x = '0, v2y = '0, pidx = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic signed [31:0] o_px, o_py, o_pz;
    logic [15:0] o_idx;
    logic        o_degen;

    // local copy of the register file
    logic [53:0] m_inv [3];
    logic [53:0] m_rot [3];
    logic [53:0] m_trans;
    logic [11:0] m_height;

    t_point expected_points[$];
    int     mismatches = 0;
    int     cycles = 0;
    int     burst_left = 0;
    bit     stall_mode = 0;

    two_view_point_triangulation dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_view1_x(v1x), .i_view1_y(v1y), .i_view2_x(v2x), .i_view2_y(v2y),
        .i_point_index(pidx),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_point_x(o_px), .o_point_y(o_py), .o_point_z(o_pz),
        .o_out_index(o_idx), .o_degenerate(o_degen)
    );

    always #2 clk = ~clk;

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    // signed Q2.16 coefficient k of a packed row
    function automatic longint coef(input logic [53:0] w, input int k);
        logic [17:0] f;
        f = w[18*k +: 18];
        return longint'($signed(f));
    endfunction

    // floor(v / 2^k + 1/2)
    function automatic longint rnd_shift(input longint v, input int k);
        longint t;
        t = v + (longint'(1) <<< (k - 1));
        return t >>> k;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // pixel pair to normalized point in Q.16
    task automatic normalize_px(input logic [15:0] x, input logic [15:0] y,
                                output longint o[3]);
        longint xs, ys, s;
        xs = longint'(x);
        ys = longint'(m_height) * 16 - longint'(y);
        for (int r = 0; r < 3; r++) begin
            s = coef(m_inv[r], 0) * xs + coef(m_inv[r], 1) * ys + coef(m_inv[r], 2) * 16;
            o[r] = rnd_shift(s, 4);
        end
    endtask

    task automatic cross_q16(input longint w[3], input longint u[3], output longint v[3]);
        v[0] = clamp32(rnd_shift(w[1] * u[2] - w[2] * u[1], 16));
        v[1] = clamp32(rnd_shift(w[2] * u[0] - w[0] * u[2], 16));
        v[2] = clamp32(rnd_shift(w[0] * u[1] - w[1] * u[0], 16));
    endtask

    // depth and reconstructed point of one match
    task automatic triangulate(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] bx, input logic [15:0] by,
                               input logic [15:0] idx, output t_point p);
        longint x1[3], x2[3], c[3], t[3], a[3], b[3];
        longint s, d, prod;
        logic [127:0] pos, neg, aa, num, q, r;
        logic [16:0] frac;
        logic [127:0] mag;
        bit negd;
        normalize_px(ax, ay, x1);
        normalize_px(bx, by, x2);
        for (int i = 0; i < 3; i++) begin
            s = coef(m_rot[i], 0) * x1[0] + coef(m_rot[i], 1) * x1[1]
                + coef(m_rot[i], 2) * x1[2];
            c[i] = clamp32(rnd_shift(s, 16));
            t[i] = coef(m_trans, i);
        end
        cross_q16(x2, c, a);
        cross_q16(x2, t, b);
        pos = 0; neg = 0; aa = 0;
        for (int i = 0; i < 3; i++) begin
            prod = a[i] * b[i];
            if (prod >= 0) pos += 128'(prod);
            else neg += 128'(-prod);
            aa += 128'(a[i] * a[i]);
        end
        p.idx = idx;
        p.degen = (aa == 0);
        p.px = '0; p.py = '0; p.pz = '0;
        if (!p.degen) begin
            negd = pos > neg;
            num = negd ? pos - neg : neg - pos;
            q = num / aa;
            r = num % aa;
            frac = '0;
            if (q >= 65536) begin
                mag = 128'hFFFFFFFF;
            end else begin
                for (int i = 0; i < 17; i++) begin
                    frac = frac << 1;
                    if (r >= aa - r) begin
                        r = r - (aa - r);
                        frac[0] = 1'b1;
                    end else begin
                        r = r + r;
                    end
                end
                mag = (((q << 17) | 128'(frac)) + 1) >> 1;
            end
            if (negd) begin
                if (mag > 128'h80000000) mag = 128'h80000000;
                d = -longint'(mag);
            end else begin
                if (mag > 128'h7FFFFFFF) mag = 128'h7FFFFFFF;
                d = longint'(mag);
            end
            p.pz = d[31:0];
            s = clamp32(rnd_shift(d * x1[0], 16));
            p.px = s[31:0];
            s = clamp32(rnd_shift(d * x1[1], 16));
            p.py = s[31:0];
        end
    endtask

    // one apb write, setup then access
    task automatic write_reg(input tvt_pkg::t_reg_idx idx, input logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            tvt_pkg::REG_INV0, tvt_pkg::REG_INV1, tvt_pkg::REG_INV2:
                m_inv[idx] = value[53:0];
            tvt_pkg::REG_ROT0, tvt_pkg::REG_ROT1, tvt_pkg::REG_ROT2:
                m_rot[idx - tvt_pkg::REG_ROT0] = value[53:0];
            tvt_pkg::REG_TRANS:
                m_trans = value[53:0];
            default:
                m_height = value[11:0];
        endcase
    endtask

    // send one match word, with bursty gaps; valid stays high across a burst
    task automatic send_match(input logic [15:0] ax, input logic [15:0] ay,
                              input logic [15:0] bx, input logic [15:0] by,
                              input logic [15:0] idx);
        t_point p;
        int     gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) * ($urandom_range(0, 2) == 0);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        in_valid <= 1'b1;
        v1x <= ax; v1y <= ay; v2x <= bx; v2y <= by; pidx <= idx;
        triangulate(ax, ay, bx, by, idx, p);
        expected_points = {expected_points, p};
        do @(posedge clk); while (in_stall);
        burst_left--;
        @(negedge clk);
    endtask

    // called at a falling edge, right after the last accepted word
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_points.size() != 0) @(negedge clk);
        repeat (LatencyCycles) @(negedge clk);
    endtask

    // receiver stall pattern: free-running periods alternating with random stalls
    always @(negedge clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
        out_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
    end

    // compare each accepted point word with the oldest prediction
    always @(posedge clk) begin
        t_point e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected point word idx=%0d", o_idx);
            end else begin
                e = expected_points.pop_front();
                if (o_px !== e.px || o_py !== e.py || o_pz !== e.pz ||
                    o_idx !== e.idx || o_degen !== e.degen) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h %h %h %h %b got %h %h %h %h %b",
                                 e.px, e.py, e.pz, e.idx, e.degen,
                                 o_px, o_py, o_pz, o_idx, o_degen);
                end
            end
        end
    end

    function automatic logic [53:0] pack_row(input logic [17:0] c0, input logic [17:0] c1,
                                             input logic [17:0] c2);
        return {c2, c1, c0};
    endfunction

    function automatic logic [17:0] rnd_coef();
        case ($urandom_range(0, 5))
            0: return 18'h1FFFF;
            1: return 18'h20000;
            2: return 18'h0;
            default: return 18'($signed($urandom_range(0, 65536 * 2)) - 65536);
        endcase
    endfunction

    function automatic logic [15:0] rnd_pix();
        case ($urandom_range(0, 7))
            0: return 16'hFFFF;
            1: return 16'h0;
            default: return 16'($urandom_range(0, 640 * 16));
        endcase
    endfunction

    // corner inputs and degenerate cases under the reset registers, then with a translation written
    task automatic test_directed();
        send_match(16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_match(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_match(16'h1400, 16'h0F00, 16'h1400, 16'h0F00, 16'h1234);
        drain();
        write_reg(tvt_pkg::REG_TRANS, pack_row(18'h10000, 18'h0, 18'h0));
        send_match(16'h1400, 16'h0F00, 16'h1480, 16'h0F00, 16'h0001);
        send_match(16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0002);
        send_match(16'hFFFF, 16'h0, 16'h0, 16'hFFFF, 16'hAAAA);
        send_match(16'h0, 16'hFFFF, 16'hFFFF, 16'h0, 16'h5555);
        drain();
    endtask

    // extremes of the height, translation, first rotation and first inverse rows, with matches after each set
    task automatic test_registers();
        write_reg(tvt_pkg::REG_HEIGHT, 64'd4095);
        write_reg(tvt_pkg::REG_TRANS, pack_row(18'h1FFFF, 18'h20000, 18'h1FFFF));
        write_reg(tvt_pkg::REG_ROT0, pack_row(18'h1FFFF, 18'h20000, 18'h10000));
        send_match(16'hFFFF, 16'h0, 16'h8000, 16'h1, 16'h0003);
        send_match(16'h0, 16'hFFFF, 16'h1, 16'h8000, 16'h0004);
        drain();
        write_reg(tvt_pkg::REG_HEIGHT, 64'd1);
        write_reg(tvt_pkg::REG_INV0, 54'h3FFFFFFFFFFFFF);
        send_match(16'h8000, 16'hFFFF, 16'h7FFF, 16'h0, 16'h0005);
        send_match(16'h0010, 16'h0010, 16'h0020, 16'h0000, 16'h0006);
        drain();
    endtask

    task automatic test_random();
        for (int set = 0; set < 12; set++) begin
            for (int r = 0; r < 3; r++) begin
                write_reg(tvt_pkg::t_reg_idx'(int'(tvt_pkg::REG_INV0) + r),
                          ($urandom_range(0, 3) == 0) ?
                          54'($urandom) << 22 ^ 54'($urandom) :
                          pack_row(r == 0 ? 18'h00080 : 18'h0, r == 1 ? 18'h00080 : 18'h0,
                                   r == 2 ? 18'h10000 : rnd_coef() >>> 6));
                write_reg(tvt_pkg::t_reg_idx'(int'(tvt_pkg::REG_ROT0) + r),
                          ($urandom_range(0, 3) == 0) ?
                          pack_row(rnd_coef(), rnd_coef(), rnd_coef()) :
                          pack_row(r == 0 ? 18'h10000 : 18'h0, r == 1 ? 18'h10000 : 18'h0,
                                   r == 2 ? 18'h10000 : 18'h0));
            end
            write_reg(tvt_pkg::REG_TRANS, pack_row(rnd_coef(), rnd_coef(), rnd_coef()));
            write_reg(tvt_pkg::REG_HEIGHT,
                      (set == 0) ? 64'd4095 : 64'($urandom_range(1, 4095)));
            for (int k = 0; k < 100; k++)
                send_match(rnd_pix(), rnd_pix(), rnd_pix(), rnd_pix(), 16'($urandom));
            drain();
        end
    endtask

    initial begin
        m_inv[0] = tvt_pkg::RstInv0; m_inv[1] = tvt_pkg::RstInv1;
        m_inv[2] = tvt_pkg::RstInv2;
        m_rot[0] = tvt_pkg::RstInv0; m_rot[1] = tvt_pkg::RstInv1;
        m_rot[2] = tvt_pkg::RstInv2;
        m_trans = tvt_pkg::RstTrans; m_height = tvt_pkg::RstHeight;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_registers();
        test_random();
        if (mismatches == 0 && expected_points.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/tvt_pkg.sv
hdl/tvt_cfg.sv
hdl/tvt_front.sv
hdl/tvt_dots.sv
hdl/tvt_div.sv
hdl/tvt_back.sv
hdl/two_view_point_triangulation.sv
test/testbench.sv
